@@ design/assert_macros.svh @@
// Assertion macros for the design files; beq_ctrl.sv includes them.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_NEVER(label, cond, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

@@ design/beq_pkg.sv @@
`timescale 1ns / 1ps
package beq_pkg;

    localparam int QUEUE_DEPTH  = 8;
    localparam int BUTTON_COUNT = 7;

    localparam int MASK_W  = 8;
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = IDX_W + 1;
    localparam int COUNT_W = 4;

    localparam logic [MASK_W-1:0] FOLD_MASK =
        MASK_W'((9'd1 << BUTTON_COUNT) - 9'd1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_CONSUME = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef struct packed {
        logic [MASK_W-1:0] pressed;
        logic [MASK_W-1:0] released;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } ram_req_t;

    typedef struct packed {
        logic [MASK_W-1:0] head_pressed;
        logic [MASK_W-1:0] head_released;
        logic [CNT_W-1:0]  count;
        logic              dropped;
        logic              overflow;
    } result_t;

    // Ring index arithmetic: both operands lie below QUEUE_DEPTH.
    function automatic logic [IDX_W-1:0] slot_of(
        input logic [IDX_W-1:0] base,
        input logic [IDX_W-1:0] offset
    );
        logic [SUM_W-1:0] sum;
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= SUM_W'(QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

@@ design/button_edge_queue_with_click_folding.sv @@
`timescale 1ns / 1ps
// Queue of button edge events with release folding.
// Input channel: in_valid, in_stall, operation, pressed_mask, released_mask.
// A transfer happens at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid, out_stall and the six result fields, one result
// per input transfer; the result sits in an output register until taken.
// Configuration: navigation_mask is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high. Write it only while the block is idle.
// Sequence: consume, clear and the unused code pass S_HREAD and S_DONE to
// the output register. An enqueue may first run a newest-first release search
// over the queued entries (S_FREAD, S_FMOD per entry, at most 8), then S_APPEND,
// S_HREAD, S_DONE. The entry memory has a registered read port. One item is
// in flight at a time; the next transfer is taken the cycle after the result
// moves into the output register, even while that result is still stalled.
// Reset empties the queue, clears the overflow flag and sets the navigation
// mask to 60. While the receiver stalls, a finished result waits in the
// sequencer and in_stall stays high.
module button_edge_queue_with_click_folding (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 operation,
    input  logic [beq_pkg::MASK_W-1:0] pressed_mask,
    input  logic [beq_pkg::MASK_W-1:0] released_mask,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [beq_pkg::MASK_W-1:0] head_pressed,
    output logic [beq_pkg::MASK_W-1:0] head_released,
    output logic [3:0]                 pending_count,
    output logic                       navigation_only,
    output logic                       edge_dropped,
    output logic                       overflow_noted,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [beq_pkg::MASK_W-1:0] navigation_mask
);

    beq_pkg::ram_req_t          ram_req;
    beq_pkg::entry_t            ram_rd_data;
    beq_pkg::result_t           res;
    logic                       res_valid;
    logic                       res_take;
    logic [beq_pkg::MASK_W-1:0] nav_mask_reg;
    logic [beq_pkg::MASK_W-1:0] edges;
    logic                       out_valid_reg;
    logic [beq_pkg::MASK_W-1:0] head_pressed_reg;
    logic [beq_pkg::MASK_W-1:0] head_released_reg;
    logic [3:0]                 pending_count_reg;
    logic                       navigation_only_reg;
    logic                       edge_dropped_reg;
    logic                       overflow_noted_reg;

    beq_ram #(
        .WIDTH (beq_pkg::ENTRY_W),
        .DEPTH (beq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rd_data)
    );

    beq_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .pressed_mask  (pressed_mask),
        .released_mask (released_mask),
        .ram_req       (ram_req),
        .ram_rd_data   (ram_rd_data),
        .res_valid     (res_valid),
        .res_take      (res_take),
        .res           (res)
    );

    assign cfg_ready = 1'b1;
    assign res_take  = res_valid && (!out_valid_reg || !out_stall);
    assign edges     = res.head_pressed | res.head_released;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nav_mask_reg  <= beq_pkg::MASK_W'(60);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                nav_mask_reg <= navigation_mask;
            end
            if (res_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            head_pressed_reg    <= res.head_pressed;
            head_released_reg   <= res.head_released;
            pending_count_reg   <= 4'(res.count);
            navigation_only_reg <= (edges != '0) && ((edges & ~nav_mask_reg) == '0);
            edge_dropped_reg    <= res.dropped;
            overflow_noted_reg  <= res.overflow;
        end
    end

    assign out_valid       = out_valid_reg;
    assign head_pressed    = head_pressed_reg;
    assign head_released   = head_released_reg;
    assign pending_count   = pending_count_reg;
    assign navigation_only = navigation_only_reg;
    assign edge_dropped    = edge_dropped_reg;
    assign overflow_noted  = overflow_noted_reg;

endmodule

@@ design/beq_ram.sv @@
`timescale 1ns / 1ps
module beq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/beq_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module beq_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    operation,
    input  logic [beq_pkg::MASK_W-1:0]    pressed_mask,
    input  logic [beq_pkg::MASK_W-1:0]    released_mask,
    output beq_pkg::ram_req_t             ram_req,
    input  beq_pkg::entry_t               ram_rd_data,
    output logic                          res_valid,
    input  logic                          res_take,
    output beq_pkg::result_t              res
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FREAD  = 6'b000010,
        S_FMOD   = 6'b000100,
        S_APPEND = 6'b001000,
        S_HREAD  = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t                       state_reg, state_next;
    logic [beq_pkg::MASK_W-1:0]   pressed_reg, pressed_next;
    logic [beq_pkg::MASK_W-1:0]   released_reg, released_next;
    logic [beq_pkg::MASK_W-1:0]   pending_reg, pending_next;
    logic [beq_pkg::IDX_W-1:0]    k_reg, k_next;
    logic [beq_pkg::IDX_W-1:0]    slot_reg, slot_next;
    logic [beq_pkg::IDX_W-1:0]    head_reg, head_next;
    logic [beq_pkg::CNT_W-1:0]    count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         dropped_reg, dropped_next;

    logic [beq_pkg::MASK_W-1:0]   fold;
    logic [beq_pkg::MASK_W-1:0]   leftover;
    logic [beq_pkg::IDX_W-1:0]    scan_slot;
    logic [beq_pkg::IDX_W-1:0]    tail_slot;
    logic                         in_xfer;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign res_valid = (state_reg == S_DONE);

    assign fold      = pending_reg & ram_rd_data.pressed & ~ram_rd_data.released;
    assign leftover  = (released_reg & ~beq_pkg::FOLD_MASK) | pending_reg;
    assign scan_slot = beq_pkg::slot_of(head_reg, k_reg);
    assign tail_slot = beq_pkg::slot_of(head_reg, count_reg[beq_pkg::IDX_W-1:0]);

    always_comb
    begin
        state_next    = state_reg;
        pressed_next  = pressed_reg;
        released_next = released_reg;
        pending_next  = pending_reg;
        k_next        = k_reg;
        slot_next     = slot_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        dropped_next  = dropped_reg;
        ram_req       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    pressed_next  = pressed_mask;
                    released_next = released_mask;
                    pending_next  = released_mask & beq_pkg::FOLD_MASK;
                    dropped_next  = 1'b0;
                    k_next        = beq_pkg::IDX_W'(count_reg - beq_pkg::CNT_W'(1));
                    state_next    = S_HREAD;
                    unique case (beq_pkg::op_t'(operation))
                        beq_pkg::OP_ENQUEUE:
                        begin
                            if (count_reg == '0 ||
                                (released_mask & beq_pkg::FOLD_MASK) == '0)
                            begin
                                state_next = S_APPEND;
                            end
                            else
                            begin
                                state_next = S_FREAD;
                            end
                        end
                        beq_pkg::OP_CONSUME:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = beq_pkg::slot_of(head_reg, beq_pkg::IDX_W'(1));
                                count_next = count_reg - beq_pkg::CNT_W'(1);
                                if (count_reg == beq_pkg::CNT_W'(1))
                                begin
                                    ovf_next = 1'b0;
                                end
                            end
                        end
                        beq_pkg::OP_CLEAR:
                        begin
                            head_next  = '0;
                            count_next = '0;
                            ovf_next   = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FREAD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = scan_slot;
                slot_next       = scan_slot;
                state_next      = S_FMOD;
            end
            S_FMOD:
            begin
                // The entry is written back in the cycle its data returns, and the
                // next read goes to an older slot, so accesses never overlap.
                if (fold != '0)
                begin
                    ram_req.wr_en            = 1'b1;
                    ram_req.wr_addr          = slot_reg;
                    ram_req.wr_data.pressed  = ram_rd_data.pressed;
                    ram_req.wr_data.released = ram_rd_data.released | fold;
                end
                pending_next = pending_reg & ~fold;
                if (k_reg == '0 || (pending_reg & ~fold) == '0)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    k_next     = k_reg - beq_pkg::IDX_W'(1);
                    state_next = S_FREAD;
                end
            end
            S_APPEND:
            begin
                if (pressed_reg != '0 || leftover != '0)
                begin
                    if (count_reg == beq_pkg::CNT_W'(beq_pkg::QUEUE_DEPTH))
                    begin
                        ovf_next     = 1'b1;
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        ram_req.wr_en            = 1'b1;
                        ram_req.wr_addr          = tail_slot;
                        ram_req.wr_data.pressed  = pressed_reg;
                        ram_req.wr_data.released = leftover;
                        count_next               = count_reg + beq_pkg::CNT_W'(1);
                    end
                end
                state_next = S_HREAD;
            end
            S_HREAD:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = head_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res               = '0;
        res.count         = count_reg;
        res.dropped       = dropped_reg;
        res.overflow      = ovf_reg;
        if (count_reg != '0)
        begin
            res.head_pressed  = ram_rd_data.pressed;
            res.head_released = ram_rd_data.released;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            dropped_reg <= dropped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pressed_reg  <= pressed_next;
        released_reg <= released_next;
        pending_reg  <= pending_next;
        k_reg        <= k_next;
        slot_reg     <= slot_next;
    end

    `ASSERT_ALWAYS(a_count_bound, count_reg <= beq_pkg::CNT_W'(beq_pkg::QUEUE_DEPTH), "count above depth")
    `ASSERT_ALWAYS(a_head_bound, {1'b0, head_reg} < beq_pkg::SUM_W'(beq_pkg::QUEUE_DEPTH), "head out of range")
    `ASSERT_IMPLY(a_drop_full, res_valid && dropped_reg, count_reg == beq_pkg::CNT_W'(beq_pkg::QUEUE_DEPTH), "drop while not full")
    `ASSERT_IMPLY(a_ovf_nonempty, ovf_reg, count_reg != '0, "overflow flag on empty queue")
    `ASSERT_NEVER(a_ram_overlap, ram_req.wr_en && ram_req.rd_en, "read and write in one cycle")

endmodule
